>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define FP4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define FP4_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fp4bd_pkg.sv
// ---------------------------------------------------------------------------
// fp4bd_pkg
// Types, constants and decode functions of the FP4 block dot accumulator.
// ---------------------------------------------------------------------------
package fp4bd_pkg;

  localparam int unsigned NumLanes   = 16;
  localparam int unsigned NibW       = 4;
  localparam int unsigned BlockW     = NumLanes * NibW;
  localparam int unsigned ScaleW     = 8;
  localparam int unsigned ScaleValW  = 18;   // E4M3 value in units of 2^-9
  localparam int unsigned ProdW      = 9;    // one lane product, units of 1/4
  localparam int unsigned DotW       = 13;   // sum of 16 lane products
  localparam int unsigned TermW      = 50;
  localparam int unsigned AccW       = 64;
  localparam int unsigned AlphaW     = 32;
  localparam int unsigned Bf16W      = 16;
  localparam int unsigned WideW      = 88;   // 64 x 24 bit magnitude product
  localparam int unsigned LzW        = 7;
  localparam int unsigned ExpW       = 10;   // signed exponent arithmetic
  localparam int unsigned KeepPos    = 80;   // msb at 87 keeps 8 bits
  localparam int unsigned InDataW    = 2 * BlockW + 2 * ScaleW;

  localparam logic [Bf16W-1:0] Bf16Nan = 16'h7FC0;
  localparam logic [Bf16W-1:0] Bf16Inf = 16'h7F80;
  localparam logic [AlphaW-1:0] AlphaReset = 32'h3F80_0000;
  localparam logic [7:0] AlphaExpMax = 8'hFF;

  typedef logic signed [ProdW-1:0] lane_prod_t;
  typedef logic signed [DotW-1:0]  dot_t;

  // Request from the accumulator stage to the bf16 converter
  typedef struct packed {
    logic              start;
    logic [AccW-1:0]   acc;
    logic [AlphaW-1:0] alpha;
  } cvt_req_t;

  // Converter status back to the top level
  typedef struct packed {
    logic             idle;
    logic             res_valid;
    logic [Bf16W-1:0] res;
  } cvt_stat_t;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_MUL,
    CV_SUM,
    CV_NORM,
    CV_ALIGN,
    CV_ROUND,
    CV_DONE
  } cvt_state_t;

  // E2M1 magnitude in units of 0.5
  function automatic logic [3:0] fp4_mag(input logic [2:0] code);
    logic [3:0] m;
    case (code)
      3'd0:    m = 4'd0;
      3'd1:    m = 4'd1;
      3'd2:    m = 4'd2;
      3'd3:    m = 4'd3;
      3'd4:    m = 4'd4;
      3'd5:    m = 4'd6;
      3'd6:    m = 4'd8;
      default: m = 4'd12;
    endcase
    return m;
  endfunction

  // Unsigned E4M3 scale in units of 2^-9, bit 7 ignored
  function automatic logic [ScaleValW-1:0] scale_val(input logic [ScaleW-1:0] b);
    logic [3:0] e;
    logic [ScaleValW-1:0] mant;
    e    = b[6:3];
    mant = {{(ScaleValW-4){1'b0}}, 1'b1, b[2:0]};
    if (e == 4'd0) begin
      return {{(ScaleValW-3){1'b0}}, b[2:0]};
    end
    return mant << (e - 4'd1);
  endfunction

endpackage

>>> src/fp4_block_scaled_dot_accumulator_core.sv
// ---------------------------------------------------------------------------
// fp4_block_scaled_dot_accumulator_core
// FP4 E2M1 block-scaled dot product accumulator with bf16 row output.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_     | in  | tdata: weight_block, act_block, weight_scale, act_scale;
//          |     | tlast: last_block
//  out_    | out | tdata: row_result (bf16)
//  cfg_    | in  | wdata: alpha_bits (fp32), written when cfg_we is high
//
//  A block passes lane products and merge alongside the scale multiply,
//  then term multiply and accumulate, before the next accept; a last block
//  also starts the bf16 converter (multiply, sum, 7 normalize steps, align, round).
//  A new row may enter while the converter runs; a second last block waits
//  in the accumulate stage until the converter is free.
//  Reset (rst_n low, synchronous) clears the accumulator and sets alpha 1.0.
// ---------------------------------------------------------------------------
module fp4_block_scaled_dot_accumulator_core
  import fp4bd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // weight_block[63:0], act_block[127:64], weight_scale[135:128], act_scale[143:136]
  input  logic [InDataW-1:0] in_tdata,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  // row_result[15:0]
  output logic [Bf16W-1:0]   out_tdata,
  input  logic               cfg_we,
  input  logic [AlphaW-1:0]  cfg_wdata
);

  logic                busy_r;
  logic [BlockW-1:0]   wb_r, ab_r;
  logic [ScaleW-1:0]   ws_r, as_r;
  logic                v0_r, v1_r, v2_r;
  logic                last0_r, last1_r, last2_r;
  logic [2*ScaleValW-1:0] sp_r;
  logic signed [TermW-1:0] term_r;
  logic [AccW-1:0]     acc_r;
  logic [AlphaW-1:0]   alpha_r;
  logic                out_valid_r;
  logic [Bf16W-1:0]    out_data_r;

  lane_prod_t          prod [NumLanes];
  dot_t                dot_r;
  logic                accept, fire, out_load;
  logic [AccW:0]       sum_ext;
  logic [AccW-1:0]     acc_sat;
  cvt_req_t            cvt_req;
  cvt_stat_t           cvt_stat;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign fire      = v2_r && (!last2_r || cvt_stat.idle);

  // element lanes
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    fp4bd_lane u_lane (
      .w_nib (wb_r[i*NibW +: NibW]),
      .a_nib (ab_r[i*NibW +: NibW]),
      .prod  (prod[i])
    );
  end

  fp4bd_merge u_merge (
    .clk   (clk),
    .prod  (prod),
    .dot_r (dot_r)
  );

  // saturating accumulate
  always_comb begin
    sum_ext = {acc_r[AccW-1], acc_r} + (AccW+1)'(term_r);
    if (sum_ext[AccW] != sum_ext[AccW-1]) begin
      acc_sat = sum_ext[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = sum_ext[AccW-1:0];
    end
  end

  assign cvt_req.start = fire && last2_r;
  assign cvt_req.acc   = acc_sat;
  assign cvt_req.alpha = alpha_r;

  fp4bd_bf16 u_bf16 (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (cvt_req),
    .res_ready (out_load),
    .stat      (cvt_stat)
  );

  assign out_load   = cvt_stat.res_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      acc_r       <= '0;
      alpha_r     <= AlphaReset;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      v0_r <= accept;
      v1_r <= v0_r;
      if (v1_r) begin
        v2_r <= 1'b1;
      end else if (fire) begin
        v2_r <= 1'b0;
      end
      if (fire) begin
        acc_r <= last2_r ? '0 : acc_sat;
      end
      if (cfg_we) begin
        alpha_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      wb_r    <= in_tdata[0 +: BlockW];
      ab_r    <= in_tdata[BlockW +: BlockW];
      ws_r    <= in_tdata[2*BlockW +: ScaleW];
      as_r    <= in_tdata[2*BlockW+ScaleW +: ScaleW];
      last0_r <= in_tlast;
    end
    if (v0_r) begin
      sp_r    <= (2*ScaleValW)'(scale_val(ws_r)) * (2*ScaleValW)'(scale_val(as_r));
      last1_r <= last0_r;
    end
    if (v1_r) begin
      term_r  <= $signed({1'b0, sp_r}) * dot_r;
      last2_r <= last1_r;
    end
    if (out_load) begin
      out_data_r <= cvt_stat.res;
    end
  end

endmodule

>>> src/fp4bd_lane.sv
// ---------------------------------------------------------------------------
// fp4bd_lane
// One element lane: signed product of a weight and an activation nibble.
// ---------------------------------------------------------------------------
module fp4bd_lane
  import fp4bd_pkg::*;
(
  input  logic [NibW-1:0] w_nib,
  input  logic [NibW-1:0] a_nib,
  output lane_prod_t      prod
);

  logic [7:0] mag;

  // magnitude product in units of 1/4, sign from the two sign bits
  assign mag  = 8'(fp4_mag(w_nib[2:0])) * 8'(fp4_mag(a_nib[2:0]));
  assign prod = (w_nib[3] ^ a_nib[3]) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

>>> src/fp4bd_merge.sv
// ---------------------------------------------------------------------------
// fp4bd_merge
// Adds the 16 lane products into the block dot product, registered.
// ---------------------------------------------------------------------------
module fp4bd_merge
  import fp4bd_pkg::*;
(
  input  logic       clk,
  input  lane_prod_t prod [NumLanes],
  output dot_t       dot_r
);

  dot_t dot_nxt;

  // adder chain over independent lanes
  always_comb begin
    dot_nxt = '0;
    for (int i = 0; i < NumLanes; i++) begin
      dot_nxt = dot_nxt + DotW'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    dot_r <= dot_nxt;
  end

endmodule

>>> src/fp4bd_bf16.sv
// ---------------------------------------------------------------------------
// fp4bd_bf16
// Multi-cycle converter: acc * 2^-20 * alpha rounded once to bf16 (RNE).
// ---------------------------------------------------------------------------
module fp4bd_bf16
  import fp4bd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cvt_req_t  req,
  input  logic      res_ready,
  output cvt_stat_t stat
);

  cvt_state_t state_r, state_nxt;

  logic [AccW-1:0]    mag_r;
  logic               sign_r;
  logic [7:0]         aexp_r;
  logic [23:0]        ma_r;
  logic [55:0]        p0_r, p1_r;
  logic [WideW-1:0]   n_r;
  logic [LzW-1:0]     lz_r;
  logic [2:0]         step_r;
  logic [7:0]         qm_r;
  logic               guard_r, sticky_r;
  logic signed [ExpW-1:0] lsb_r;
  logic [Bf16W-1:0]   res_r;

  // request decode
  logic               acc_neg;
  logic [7:0]         req_aexp;
  logic [22:0]        req_afrac;
  logic               req_sign;

  // normalize step
  logic [LzW-1:0]     sh_amt;
  logic [WideW-1:0]   top_mask;

  // align
  logic signed [ExpW-1:0] e_val, t_raw, t_val, lsb_val, keep_pos;
  logic [LzW-1:0]     t_m1;
  logic [WideW-1:0]   shifted, low_mask;

  // round and pack
  logic [8:0]         qm9;
  logic [7:0]         q_fin;
  logic signed [ExpW-1:0] lsb_fin, bexp;

  assign acc_neg   = req.acc[AccW-1];
  assign req_aexp  = req.alpha[30:23];
  assign req_afrac = req.alpha[22:0];
  assign req_sign  = req.alpha[31] ^ acc_neg;

  assign sh_amt   = LzW'(1) << (3'd6 - step_r);
  assign top_mask = ~({WideW{1'b1}} >> sh_amt);

  // exponent of the product's lsb, and the kept window position in n_r
  always_comb begin
    keep_pos = $signed(ExpW'(KeepPos));
    e_val   = ExpW'(signed'({2'b00, (aexp_r == 8'd0) ? 8'd1 : aexp_r})) - ExpW'(170);
    t_raw   = -ExpW'(133) - e_val + ExpW'(signed'({3'b000, lz_r}));
    t_val   = (t_raw < keep_pos) ? keep_pos : t_raw;
    t_m1    = LzW'(t_val - ExpW'(1));
    lsb_val = e_val + t_val - ExpW'(signed'({3'b000, lz_r}));
    shifted = n_r >> t_m1;
    low_mask = ~({WideW{1'b1}} << t_m1);
  end

  always_comb begin
    qm9     = {1'b0, qm_r} + 9'(guard_r & (sticky_r | qm_r[0]));
    q_fin   = qm9[8] ? qm9[8:1] : qm9[7:0];
    lsb_fin = qm9[8] ? lsb_r + ExpW'(1) : lsb_r;
    bexp    = lsb_fin + ExpW'(134);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE: begin
        if (req.start) begin
          if (req_aexp == AlphaExpMax || req.acc == '0 || req.alpha[30:0] == '0) begin
            state_nxt = CV_DONE;
          end else begin
            state_nxt = CV_MUL;
          end
        end
      end
      CV_MUL:   state_nxt = CV_SUM;
      CV_SUM:   state_nxt = CV_NORM;
      CV_NORM: begin
        if (step_r == 3'd6) begin
          state_nxt = CV_ALIGN;
        end
      end
      CV_ALIGN: state_nxt = CV_ROUND;
      CV_ROUND: state_nxt = CV_DONE;
      CV_DONE: begin
        if (res_ready) begin
          state_nxt = CV_IDLE;
        end
      end
      default:  state_nxt = CV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.idle      = (state_r == CV_IDLE);
    stat.res_valid = (state_r == CV_DONE);
    stat.res       = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      CV_IDLE: begin
        mag_r  <= acc_neg ? -req.acc : req.acc;
        sign_r <= req_sign;
        aexp_r <= req_aexp;
        ma_r   <= {(req_aexp != 8'd0), req_afrac};
        // special results: NaN/inf alpha, zero product
        if (req_aexp == AlphaExpMax) begin
          res_r <= (req_afrac != '0 || req.acc == '0) ? Bf16Nan : (Bf16Inf | {req_sign, 15'd0});
        end else begin
          res_r <= {req_sign, 15'd0};
        end
      end
      CV_MUL: begin
        p0_r <= 56'(mag_r[31:0])  * 56'(ma_r);
        p1_r <= 56'(mag_r[63:32]) * 56'(ma_r);
      end
      CV_SUM: begin
        n_r    <= {32'd0, p0_r} + {p1_r, 32'd0};
        lz_r   <= '0;
        step_r <= '0;
      end
      CV_NORM: begin
        // shift out leading zeros 64, 32, ... 1 at a time
        if ((n_r & top_mask) == '0) begin
          n_r  <= n_r << sh_amt;
          lz_r <= lz_r + sh_amt;
        end
        step_r <= step_r + 3'd1;
      end
      CV_ALIGN: begin
        qm_r     <= shifted[8:1];
        guard_r  <= shifted[0];
        sticky_r <= (n_r & low_mask) != '0;
        lsb_r    <= lsb_val;
      end
      CV_ROUND: begin
        if (q_fin[7]) begin
          if (bexp >= ExpW'(255)) begin
            res_r <= {sign_r, 15'd0} | Bf16Inf;
          end else begin
            res_r <= {sign_r, bexp[7:0], q_fin[6:0]};
          end
        end else begin
          res_r <= {sign_r, 8'd0, q_fin[6:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/fp4bd_checker.sv
// ---------------------------------------------------------------------------
// fp4bd_checker
// Port-level checks of the accumulator core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fp4bd_checker
  import fp4bd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [Bf16W-1:0]   out_tdata
);

  // result beat holds until taken
  `FP4_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "out beat dropped")
  `FP4_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "out data changed")
  // one block at a time: ready drops after every accepted beat
  `FP4_ASSERT(a_one_block, in_tvalid && in_tready |=> !in_tready, "second block taken")
  // nothing shows on the output straight after reset
  `FP4_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind fp4_block_scaled_dot_accumulator_core fp4bd_checker u_fp4bd_checker (.*);
